// File: hdl/buddy_block_allocator_core_assert.svh
// assertion macros for the buddy allocator core
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication, clocked on clk, off during rst
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// next-cycle implication, clocked on clk, off during rst
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`else

`define BBA_ASSERT_NOW(lbl, ante, cons)
`define BBA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/bba_pkg.sv
package bba_pkg;

  localparam int TREE_LEVELS_DEF = 10;

  localparam int CMD_W   = 1;
  localparam int REQ_W   = 25;
  localparam int OFF_W   = 24;
  localparam int SIZE_W  = 25;
  localparam int ST_W    = 2;
  localparam int ORD_W   = 5;
  localparam int SH_W    = 25;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam int S_TDATA_W = ((REQ_W + OFF_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((ST_W + OFF_W + SIZE_W + 7) / 8) * 8;

  localparam logic [ORD_W-1:0] POOL_ORDER_RESET = 5'd12;
  localparam logic [ORD_W-1:0] MIN_ORDER_RESET  = 5'd4;
  localparam logic [ORD_W-1:0] POOL_ORDER_LO    = 5'd3;
  localparam logic [ORD_W-1:0] POOL_ORDER_HI    = 5'd24;
  localparam logic [ORD_W-1:0] MIN_ORDER_FLOOR  = 5'd2;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_ORDER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ORDER  = 1'd1;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

  typedef enum logic [1:0] {
    MARK_UNUSED = 2'd0,
    MARK_USED   = 2'd1,
    MARK_SPLIT  = 2'd2,
    MARK_FULL   = 2'd3
  } mark_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] block_offset;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [OFF_W-1:0]  granted_offset;
    logic [SIZE_W-1:0] granted_size;
  } res_t;

  typedef struct packed {
    logic [ORD_W-1:0] pool_order;
    logic [ORD_W-1:0] min_order;
    logic [ORD_W-1:0] span;
  } eff_cfg_t;

  typedef struct packed {
    logic             shl;
    logic [ORD_W-1:0] amt;
    logic [SH_W-1:0]  val;
  } shift_req_t;

  function automatic logic mark_taken(mark_t m);
    return (m == MARK_USED) || (m == MARK_FULL);
  endfunction

endpackage

// File: hdl/bba_shifter.sv
module bba_shifter (
  input  bba_pkg::shift_req_t      req,
  output logic [bba_pkg::SH_W-1:0] res
);
  import bba_pkg::*;

  always_comb begin
    if (req.shl) begin
      res = req.val << req.amt;
    end else begin
      res = req.val >> req.amt;
    end
  end

endmodule

// File: hdl/bba_mark_ram.sv
module bba_mark_ram #(
  parameter int ADDR_W = bba_pkg::TREE_LEVELS_DEF + 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  bba_pkg::mark_t      wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output bba_pkg::mark_t      rdata
);
  import bba_pkg::*;

  mark_t mem [0:(1 << ADDR_W)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/bba_ctrl.sv
module bba_ctrl #(
  parameter int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  bba_pkg::eff_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  bba_pkg::item_t    in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::res_t     out_res
);
  import bba_pkg::*;

  localparam int ADDR_W  = TREE_LEVELS + 1;
  localparam int DEPTH_W = $clog2(TREE_LEVELS + 1);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_CHECK,
    S_A_ROUND,
    S_A_READ,
    S_A_EVAL,
    S_A_CLIMB,
    S_F_CHECK,
    S_F_READ,
    S_F_EVAL,
    S_P_RL,
    S_P_RR,
    S_P_EV,
    S_F_UP_RD,
    S_F_UP_EV,
    S_DONE
  } state_t;

  state_t             state;
  item_t              item;
  logic [ORD_W-1:0]   k;
  logic [DEPTH_W-1:0] dk;
  logic [DEPTH_W-1:0] depth;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  j;
  logic [ADDR_W-1:0]  clr_cnt;
  mark_t              left_mark;
  res_t               res;

  logic [ORD_W-1:0]   ord;
  logic [DEPTH_W-1:0] span_d;
  logic [ADDR_W-1:0]  idx_clr;
  logic [ADDR_W-1:0]  j_half;
  logic [ADDR_W-1:0]  j_left;
  logic [ADDR_W-1:0]  j_right;
  logic               pair_ok;
  logic               is_alloc;

  shift_req_t         sreq;
  logic [SH_W-1:0]    shres;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  mark_t              wdata;
  logic [ADDR_W-1:0]  raddr;
  mark_t              rdata;

  bba_shifter u_shifter (
    .req (sreq),
    .res (shres)
  );

  bba_mark_ram #(
    .ADDR_W (ADDR_W)
  ) u_mark_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign ord      = cfg.pool_order - ORD_W'(depth);
  assign span_d   = DEPTH_W'(cfg.span);
  assign idx_clr  = idx ^ (ADDR_W'(1) << depth);
  assign j_half   = j >> 1;
  assign j_left   = {j[ADDR_W-1:1], 1'b0};
  assign j_right  = {j[ADDR_W-1:1], 1'b1};
  assign is_alloc = (item.cmd == CMD_ALLOC);
  assign in_ready = (state == S_IDLE) && !clear;

  always_comb begin
    if (is_alloc) begin
      pair_ok = mark_taken(left_mark) && mark_taken(rdata);
    end else begin
      pair_ok = (left_mark == MARK_UNUSED) && (rdata == MARK_UNUSED);
    end
  end

  // shared shifter: size, rounding, offset, free range check and path bit all go through here
  always_comb begin
    sreq.shl = 1'b1;
    sreq.amt = '0;
    sreq.val = '0;
    case (state)
      S_A_CHECK: begin
        sreq.amt = cfg.pool_order;
        sreq.val = SH_W'(1);
      end
      S_A_ROUND: begin
        sreq.amt = k;
        sreq.val = SH_W'(1);
      end
      S_A_EVAL: begin
        sreq.amt = ord;
        sreq.val = SH_W'(idx_clr);
      end
      S_F_CHECK: begin
        sreq.shl = 1'b0;
        sreq.amt = cfg.pool_order;
        sreq.val = SH_W'(item.block_offset);
      end
      S_F_EVAL: begin
        if (rdata == MARK_USED) begin
          sreq.amt = ord;
          sreq.val = SH_W'(idx_clr);
        end else begin
          sreq.shl = 1'b0;
          sreq.amt = ord - ORD_W'(1);
          sreq.val = SH_W'(item.block_offset);
        end
      end
      S_P_RL: begin
        sreq.amt = ord;
        sreq.val = SH_W'(1);
      end
      default: begin
      end
    endcase
  end

  // mark memory port
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = MARK_UNUSED;
    raddr = idx;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      S_A_EVAL: begin
        if (rdata == MARK_UNUSED && depth == dk) begin
          we    = 1'b1;
          wdata = MARK_USED;
        end else if (rdata == MARK_UNUSED && depth < dk) begin
          we    = 1'b1;
          wdata = MARK_SPLIT;
        end
      end
      S_F_EVAL: begin
        if (rdata == MARK_USED && shres[OFF_W-1:0] == item.block_offset) begin
          we    = 1'b1;
          wdata = MARK_UNUSED;
        end
      end
      S_P_RL: begin
        raddr = j_left;
      end
      S_P_RR: begin
        raddr = j_right;
      end
      S_P_EV: begin
        if (pair_ok) begin
          we    = 1'b1;
          waddr = j_half;
          wdata = is_alloc ? MARK_FULL : MARK_UNUSED;
        end
      end
      S_F_UP_RD: begin
        raddr = j_half;
      end
      S_F_UP_EV: begin
        if (rdata == MARK_FULL) begin
          we    = 1'b1;
          waddr = j;
          wdata = MARK_SPLIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (clear) begin
        state   <= S_CLEAR;
        clr_cnt <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            clr_cnt <= clr_cnt + ADDR_W'(1);
            if (clr_cnt == '1) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              item  <= in_item;
              state <= (in_item.cmd == CMD_FREE) ? S_F_CHECK : S_A_CHECK;
            end
          end
          S_A_CHECK: begin
            if (item.request_bytes > shres) begin
              res   <= '{status: ST_NO_SPACE, granted_offset: '0, granted_size: '0};
              state <= S_DONE;
            end else begin
              k     <= cfg.min_order;
              state <= S_A_ROUND;
            end
          end
          S_A_ROUND: begin
            if (shres < item.request_bytes) begin
              k <= k + ORD_W'(1);
            end else begin
              dk    <= DEPTH_W'(cfg.pool_order - k);
              idx   <= ADDR_W'(1);
              depth <= '0;
              state <= S_A_READ;
            end
          end
          S_A_READ: begin
            state <= S_A_EVAL;
          end
          S_A_EVAL: begin
            if (rdata == MARK_UNUSED && depth == dk) begin
              res.status         <= ST_DONE;
              res.granted_offset <= shres[OFF_W-1:0];
              j                  <= idx;
              state              <= S_P_RL;
            end else if ((rdata == MARK_UNUSED || rdata == MARK_SPLIT) && depth < dk) begin
              idx   <= {idx[ADDR_W-2:0], 1'b0};
              depth <= depth + DEPTH_W'(1);
              state <= S_A_READ;
            end else begin
              state <= S_A_CLIMB;
            end
          end
          S_A_CLIMB: begin
            if (idx == ADDR_W'(1)) begin
              res   <= '{status: ST_NO_SPACE, granted_offset: '0, granted_size: '0};
              state <= S_DONE;
            end else if (idx[0]) begin
              idx   <= idx >> 1;
              depth <= depth - DEPTH_W'(1);
            end else begin
              idx   <= idx + ADDR_W'(1);
              state <= S_A_READ;
            end
          end
          S_F_CHECK: begin
            if (shres != '0) begin
              res   <= '{status: ST_BAD_FREE, granted_offset: '0, granted_size: '0};
              state <= S_DONE;
            end else begin
              idx   <= ADDR_W'(1);
              depth <= '0;
              state <= S_F_READ;
            end
          end
          S_F_READ: begin
            state <= S_F_EVAL;
          end
          S_F_EVAL: begin
            if (rdata == MARK_USED) begin
              if (shres[OFF_W-1:0] != item.block_offset) begin
                res   <= '{status: ST_BAD_FREE, granted_offset: '0, granted_size: '0};
                state <= S_DONE;
              end else begin
                res.status         <= ST_DONE;
                res.granted_offset <= shres[OFF_W-1:0];
                j                  <= idx;
                state              <= S_P_RL;
              end
            end else if (depth >= span_d) begin
              res   <= '{status: ST_BAD_FREE, granted_offset: '0, granted_size: '0};
              state <= S_DONE;
            end else begin
              idx   <= {idx[ADDR_W-2:0], shres[0]};
              depth <= depth + DEPTH_W'(1);
              state <= S_F_READ;
            end
          end
          S_P_RL: begin
            res.granted_size <= shres;
            if (j == ADDR_W'(1)) begin
              if (is_alloc) begin
                state <= S_DONE;
              end else begin
                j     <= idx;
                state <= S_F_UP_RD;
              end
            end else begin
              state <= S_P_RR;
            end
          end
          S_P_RR: begin
            left_mark <= rdata;
            state     <= S_P_EV;
          end
          S_P_EV: begin
            if (pair_ok) begin
              j     <= j_half;
              state <= S_P_RL;
            end else if (is_alloc) begin
              state <= S_DONE;
            end else begin
              j     <= idx;
              state <= S_F_UP_RD;
            end
          end
          S_F_UP_RD: begin
            if (j == ADDR_W'(1)) begin
              state <= S_DONE;
            end else begin
              j     <= j_half;
              state <= S_F_UP_EV;
            end
          end
          S_F_UP_EV: begin
            if (rdata == MARK_FULL) begin
              state <= S_F_UP_RD;
            end else begin
              state <= S_DONE;
            end
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid <= 1'b1;
              out_res   <= res;
              state     <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/buddy_block_allocator_core.sv
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tuser cmd, tdata request_bytes, block_offset
// m_axis    out  m_axis_tvalid/tready    tdata status, granted_offset, granted_size
// cfg       in   cfg_we                  cfg_index, cfg_wdata
//
// alloc: size check, rounding steps up from min order, a read and an evaluation per node
//   visited in the search, climb steps, full-mark levels, then the handoff
// free: range check, a read and an evaluation per level descended, merge levels, full ancestors
// node work is paced by the single read port of the mark memory
// reset and every cfg write sweep every entry of the mark memory
//   back to unused, with s_axis_tready low
// a finished result waits in the output register while the next item is taken
`include "buddy_block_allocator_core_assert.svh"

module buddy_block_allocator_core #(
  parameter int TREE_LEVELS = bba_pkg::TREE_LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // request_bytes, block_offset
  input  logic [bba_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // cmd
  input  logic [bba_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status, granted_offset, granted_size
  output logic [bba_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]         cfg_wdata
);
  import bba_pkg::*;

  localparam logic [ORD_W-1:0] TL_ORD = ORD_W'(TREE_LEVELS);

  logic [ORD_W-1:0] pool_order;
  logic [ORD_W-1:0] min_order;
  eff_cfg_t         eff;
  item_t            in_item;
  res_t             out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_order <= POOL_ORDER_RESET;
      min_order  <= MIN_ORDER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL_ORDER: pool_order <= cfg_wdata;
        REG_MIN_ORDER:  min_order  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // saturate pool order, then clamp min order between its floors and the pool
  always_comb begin
    logic [ORD_W-1:0] po;
    logic [ORD_W-1:0] lo;
    logic [ORD_W-1:0] mo;
    po = pool_order;
    if (po < POOL_ORDER_LO) begin
      po = POOL_ORDER_LO;
    end
    if (po > POOL_ORDER_HI) begin
      po = POOL_ORDER_HI;
    end
    lo = (po > TL_ORD) ? po - TL_ORD : '0;
    mo = min_order;
    if (mo < MIN_ORDER_FLOOR) begin
      mo = MIN_ORDER_FLOOR;
    end
    if (mo < lo) begin
      mo = lo;
    end
    if (mo > po) begin
      mo = po;
    end
    eff.pool_order = po;
    eff.min_order  = mo;
    eff.span       = po - mo;
  end

  assign in_item.cmd           = s_axis_tuser;
  assign in_item.request_bytes = s_axis_tdata[REQ_W-1:0];
  assign in_item.block_offset  = s_axis_tdata[REQ_W +: OFF_W];

  assign m_axis_tdata = M_TDATA_W'({out_res.granted_size, out_res.granted_offset,
                                    out_res.status});

  bba_ctrl #(
    .TREE_LEVELS (TREE_LEVELS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .cfg       (eff),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  `BBA_ASSERT_NEXT(a_cfg_starts_sweep, cfg_we, !s_axis_tready)
  `BBA_ASSERT_NEXT(a_one_item_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BBA_ASSERT_NOW(a_fail_fields_zero, m_axis_tvalid && out_res.status != ST_DONE, out_res.granted_offset == '0 && out_res.granted_size == '0)

endmodule
